// ===== hdl/ffe_pkg.sv =====
// shared types and constants of the form field extractor
package ffe_pkg;

    localparam int KEY_MAX   = 30;
    localparam int KEY_W     = 5;
    localparam int VALUE_MAX = 63;
    localparam int CNT_W     = 6;
    localparam int ADDR_W    = 6;
    localparam int DATA_W    = 64;
    localparam int KIND_W    = 2;

    localparam logic [7:0] CHAR_EQ  = 8'h3D;
    localparam logic [7:0] CHAR_AMP = 8'h26;
    localparam logic [7:0] CHAR_NUL = 8'h00;

    localparam logic [KIND_W-1:0] KIND_VALUE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_END   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NONE  = 2'd2;

    localparam logic [2:0] REG_KEY_CHARS = 3'd0;
    localparam logic [2:0] REG_KEY_WORD_A = 3'd1;
    localparam logic [2:0] REG_KEY_WORD_B = 3'd2;
    localparam logic [2:0] REG_KEY_WORD_C = 3'd3;
    localparam logic [2:0] REG_KEY_WORD_D = 3'd4;

    typedef enum logic [2:0] {
        PH_SEARCH  = 3'b001,
        PH_CAPTURE = 3'b010,
        PH_DONE    = 3'b100
    } phase_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [7:0]        value_byte;
        logic              last;
    } result_t;

    typedef struct packed {
        logic [KEY_W-1:0]             key_len;
        logic [KEY_MAX-1:0][7:0]      key;
    } key_cfg_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctl_t;

endpackage

// ===== hdl/ffe_if.sv =====
// stream interfaces for body bytes and extracted results
interface ffe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] body_byte;

    modport source (output valid, output body_byte, input ready);
    modport sink (input valid, input body_byte, output ready);
endinterface

interface ffe_out_if;
    logic                      valid;
    logic                      ready;
    logic [ffe_pkg::KIND_W-1:0] kind;
    logic [7:0]                value_byte;
    logic                      last;

    modport source (output valid, output kind, output value_byte, output last, input ready);
    modport sink (input valid, input kind, input value_byte, input last, output ready);
endinterface

// ===== hdl/ffe_cfg.sv =====
// apb register file holding the key and its length
module ffe_cfg
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ffe_pkg::ADDR_W-1:0]  paddr,
    input  logic [ffe_pkg::DATA_W-1:0]  pwdata,
    output logic [ffe_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output ffe_pkg::key_cfg_t           key_cfg
);

    logic [ffe_pkg::KEY_W-1:0] key_chars_reg;
    logic [63:0]               key_word_a_reg;
    logic [63:0]               key_word_b_reg;
    logic [63:0]               key_word_c_reg;
    logic [47:0]               key_word_d_reg;
    logic                      wr_en;
    logic [2:0]                reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[ffe_pkg::ADDR_W-1:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_chars_reg  <= '0;
            key_word_a_reg <= '0;
            key_word_b_reg <= '0;
            key_word_c_reg <= '0;
            key_word_d_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                ffe_pkg::REG_KEY_CHARS:  key_chars_reg  <= pwdata[ffe_pkg::KEY_W-1:0];
                ffe_pkg::REG_KEY_WORD_A: key_word_a_reg <= pwdata;
                ffe_pkg::REG_KEY_WORD_B: key_word_b_reg <= pwdata;
                ffe_pkg::REG_KEY_WORD_C: key_word_c_reg <= pwdata;
                ffe_pkg::REG_KEY_WORD_D: key_word_d_reg <= pwdata[47:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            ffe_pkg::REG_KEY_CHARS:  prdata = {{(ffe_pkg::DATA_W-ffe_pkg::KEY_W){1'b0}},
                                               key_chars_reg};
            ffe_pkg::REG_KEY_WORD_A: prdata = key_word_a_reg;
            ffe_pkg::REG_KEY_WORD_B: prdata = key_word_b_reg;
            ffe_pkg::REG_KEY_WORD_C: prdata = key_word_c_reg;
            ffe_pkg::REG_KEY_WORD_D: prdata = {16'h0000, key_word_d_reg};
            default:                 prdata = '0;
        endcase
    end

    // lengths above the cell count saturate
    always_comb
    begin
        if (key_chars_reg > ffe_pkg::KEY_W'(ffe_pkg::KEY_MAX))
            key_cfg.key_len = ffe_pkg::KEY_W'(ffe_pkg::KEY_MAX);
        else
            key_cfg.key_len = key_chars_reg;
        key_cfg.key = {key_word_d_reg, key_word_c_reg, key_word_b_reg, key_word_a_reg};
    end

endmodule

// ===== hdl/ffe_cell.sv =====
// one match cell: tracks whether the key prefix through its char ends at the last byte
module ffe_cell
(
    input  logic              clk,
    input  logic              rst_n,
    input  ffe_pkg::cell_ctl_t ctl,
    input  logic [7:0]        body_byte,
    input  logic [7:0]        key_char,
    input  logic              prev_match,
    input  logic              term,
    output logic              match,
    output logic              hit
);

    logic match_reg;
    logic match_next;

    always_comb
    begin
        if (ctl.clear)
            match_next = 1'b0;
        else if (ctl.shift)
            match_next = prev_match & (body_byte == key_char);
        else
            match_next = match_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            match_reg <= 1'b0;
        else
            match_reg <= match_next;
    end

    assign match = match_reg;
    // key ends at this cell's position and the '=' arrives now
    assign hit   = prev_match & term & (body_byte == ffe_pkg::CHAR_EQ);

endmodule

// ===== hdl/ffe_skid.sv =====
// output register with one skid entry
module ffe_skid
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  ffe_pkg::result_t push_data,
    output logic             push_ready,
    ffe_out_if.source        out_ch
);

    logic             out_valid_reg;
    logic             out_valid_next;
    ffe_pkg::result_t out_data_reg;
    logic             skid_valid_reg;
    logic             skid_valid_next;
    ffe_pkg::result_t skid_data_reg;
    logic             pop;
    logic             load_out;

    assign pop        = out_valid_reg & out_ch.ready;
    assign load_out   = pop | ~out_valid_reg;
    assign push_ready = ~skid_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (load_out)
        begin
            out_valid_next  = skid_valid_reg | push;
            skid_valid_next = 1'b0;
        end
        else if (push)
            skid_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
            out_data_reg <= skid_valid_reg ? skid_data_reg : push_data;
        if (!load_out && push)
            skid_data_reg <= push_data;
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.kind       = out_data_reg.kind;
    assign out_ch.value_byte = out_data_reg.value_byte;
    assign out_ch.last       = out_data_reg.last;

endmodule

// ===== hdl/form_field_extractor_top.sv =====
// form field extractor top level: key match cells, capture control, output stage
//
// usage: program key_chars and key_word_a..d over apb (64-bit registers at 8*i),
// then stream a url-encoded body on in_ch one byte per transfer; a zero byte
// ends the body. the first occurrence of key followed by '=' starts capture.
// out_ch gives one transfer per value byte (at most 63 kept, rest dropped),
// then an end marker at '&' or body end; a body with no match gives not-found.
// end marker and not-found carry last = 1.
// throughput: one byte per cycle while in_ch.ready is high, set by the row of 30
// compare cells; a result passes through the output register, or the skid entry
// when out_ch stalls, before it appears on out_ch.
// the output register plus one skid entry let in_ch keep taking bytes while a
// result waits; when out_ch stalls and the skid entry fills, in_ch.ready drops
// until the receiver takes a transfer.
// reset clears the key registers, match cells, phase and output stage; the
// block is ready for bytes as soon as reset is released.
module form_field_extractor_top
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ffe_pkg::ADDR_W-1:0]  paddr,
    input  logic [ffe_pkg::DATA_W-1:0]  pwdata,
    output logic [ffe_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    ffe_in_if.sink                      in_ch,
    ffe_out_if.source                   out_ch
);

    ffe_pkg::key_cfg_t           key_cfg;
    ffe_pkg::cell_ctl_t          cell_ctl;
    ffe_pkg::phase_t             phase_reg;
    ffe_pkg::phase_t             phase_next;
    logic [ffe_pkg::CNT_W-1:0]   count_reg;
    logic [ffe_pkg::CNT_W-1:0]   count_next;
    logic [ffe_pkg::KEY_MAX-1:0] match_vec;
    logic [ffe_pkg::KEY_MAX-1:0] hit_vec;
    logic [ffe_pkg::KEY_MAX-1:0] term_vec;
    logic                        hit_full;
    logic                        key_hit;
    logic                        in_fire;
    logic                        push_ready;
    logic                        push;
    ffe_pkg::result_t            push_data;
    logic [7:0]                  b;

    ffe_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .key_cfg (key_cfg)
    );

    assign b            = in_ch.body_byte;
    assign in_ch.ready  = push_ready;
    assign in_fire      = in_ch.valid & push_ready;

    for (genvar k = 0; k < ffe_pkg::KEY_MAX; k++)
    begin : g_cell
        logic prev_match;

        if (k == 0)
        begin : g_first
            assign prev_match = 1'b1;
        end
        else
        begin : g_rest
            assign prev_match = match_vec[k-1];
        end

        // key length is k: either the configured length or a zero char here
        assign term_vec[k] = (key_cfg.key_len == ffe_pkg::KEY_W'(k)) ||
                             ((ffe_pkg::KEY_W'(k) < key_cfg.key_len) &&
                              (key_cfg.key[k] == ffe_pkg::CHAR_NUL));

        ffe_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (cell_ctl),
            .body_byte  (b),
            .key_char   (key_cfg.key[k]),
            .prev_match (prev_match),
            .term       (term_vec[k]),
            .match      (match_vec[k]),
            .hit        (hit_vec[k])
        );
    end

    assign hit_full = match_vec[ffe_pkg::KEY_MAX-1] &
                      (key_cfg.key_len == ffe_pkg::KEY_W'(ffe_pkg::KEY_MAX)) &
                      (b == ffe_pkg::CHAR_EQ);
    assign key_hit  = (|hit_vec) | hit_full;

    always_comb
    begin
        phase_next           = phase_reg;
        count_next           = count_reg;
        cell_ctl.shift       = 1'b0;
        cell_ctl.clear       = 1'b0;
        push                 = 1'b0;
        push_data.kind       = ffe_pkg::KIND_VALUE;
        push_data.value_byte = 8'h00;
        push_data.last       = 1'b0;
        if (in_fire)
        begin
            if (b == ffe_pkg::CHAR_NUL)
            begin
                cell_ctl.clear = 1'b1;
                phase_next     = ffe_pkg::PH_SEARCH;
                count_next     = '0;
            end
            unique case (phase_reg)
                ffe_pkg::PH_SEARCH:
                begin
                    if (b == ffe_pkg::CHAR_NUL)
                    begin
                        push           = 1'b1;
                        push_data.kind = ffe_pkg::KIND_NONE;
                        push_data.last = 1'b1;
                    end
                    else
                    begin
                        cell_ctl.shift = 1'b1;
                        if (key_hit)
                        begin
                            phase_next = ffe_pkg::PH_CAPTURE;
                            count_next = '0;
                        end
                    end
                end
                ffe_pkg::PH_CAPTURE:
                begin
                    if (b == ffe_pkg::CHAR_NUL || b == ffe_pkg::CHAR_AMP)
                    begin
                        push           = 1'b1;
                        push_data.kind = ffe_pkg::KIND_END;
                        push_data.last = 1'b1;
                        if (b == ffe_pkg::CHAR_AMP)
                            phase_next = ffe_pkg::PH_DONE;
                    end
                    else if (count_reg < ffe_pkg::CNT_W'(ffe_pkg::VALUE_MAX))
                    begin
                        push                 = 1'b1;
                        push_data.value_byte = b;
                        count_next           = count_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ffe_pkg::PH_SEARCH;
            count_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    ffe_skid u_skid
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .push_ready (push_ready),
        .out_ch     (out_ch)
    );

endmodule

// ===== hdl/ffe_checker.sv =====
// port-level checks on the extractor's result stream
module ffe_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [ffe_pkg::KIND_W-1:0]  out_kind,
    input logic [7:0]                  out_value_byte,
    input logic                        out_last
);

    // a stalled transfer keeps its valid
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("out valid dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_kind) && $stable(out_value_byte)
                                    && $stable(out_last))
        else $error("out payload changed while stalled");

    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_last == (out_kind != ffe_pkg::KIND_VALUE)))
        else $error("last does not match result kind");

    // zero ends the body, so it is never a value byte
    a_value_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == ffe_pkg::KIND_VALUE |-> out_value_byte != 8'h00)
        else $error("value byte of zero");

    a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind != ffe_pkg::KIND_VALUE |-> out_value_byte == 8'h00)
        else $error("marker carries a nonzero byte");

endmodule

bind form_field_extractor_top ffe_checker u_ffe_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_kind       (out_ch.kind),
    .out_value_byte (out_ch.value_byte),
    .out_last       (out_ch.last)
);
